// ===== hdl/stable_priority_job_queue_macros.svh =====
// Assertion macros used by the stable priority job queue checker
`ifndef STABLE_PRIORITY_JOB_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_JOB_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SPJQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spjq: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define SPJQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spjq: next-cycle check failed");

`endif

// ===== hdl/spjq_pkg.sv =====
// Shared types and constants of the stable priority job queue
package spjq_pkg;

  // Queue depth, derived count width and field widths
  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 16;
  localparam int OCC_W    = 5;

  // Input item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // One stored job
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } cell_ctl_t;

endpackage

// ===== hdl/spjq_cell.sv =====
// One slot of the sorted job chain: compare, hold, shift or load
module spjq_cell (
  input  logic               clk,
  input  spjq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  spjq_pkg::entry_t   prev_ent,
  input  logic               prev_place,
  input  spjq_pkg::entry_t   next_ent,
  output spjq_pkg::entry_t   ent_o,
  output logic               place_o
);

  spjq_pkg::entry_t ent_r;
  spjq_pkg::entry_t ent_nxt;

  // New job belongs at or before this slot (empty slot or strictly larger priority)
  assign place_o = !occ || (ent_r.prio > ctl.prio);
  assign ent_o   = ent_r;

  // Insert: first placing slot loads the job, later ones take from the left.
  // Remove: every slot takes from the right.
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (place_o) begin
        if (prev_place) begin
          ent_nxt = prev_ent;
        end else begin
          ent_nxt.handle = ctl.handle;
          ent_nxt.prio   = ctl.prio;
        end
      end
    end else if (ctl.rem) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hdl/stable_priority_job_queue.sv =====
// Top level of the stable priority job queue: cell chain, count and result register
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | kind, job_handle, priority_req
//   out_    | output    | out_valid / out_stall| status, handle, priority, occupancy
//
// One item is taken per clock while in_stall is low; its result shows in the following cycle from the output register.
// Every cell compares its priority with the new job in the same cycle, so the chain
// shifts or loads in one step whatever the fill level.
// in_stall is high only while a result waits and out_stall holds it back.
// rst_n (synchronous, active low) empties the queue and drops any waiting result.
module stable_priority_job_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [spjq_pkg::HANDLE_W-1:0]  in_job_handle,
  input  logic [spjq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [spjq_pkg::HANDLE_W-1:0]  out_handle,
  output logic [spjq_pkg::PRIO_W-1:0]    out_priority,
  output logic [spjq_pkg::OCC_W-1:0]     out_occupancy
);

  logic                           accept;
  logic                           full;
  logic                           empty;
  logic [spjq_pkg::CNT_W-1:0]     cnt_r;
  logic [spjq_pkg::CNT_W-1:0]     cnt_nxt;
  spjq_pkg::cell_ctl_t            ctl;
  spjq_pkg::status_t              status_nxt;
  spjq_pkg::entry_t               ent_w   [spjq_pkg::DEPTH];
  logic                           place_w [spjq_pkg::DEPTH];
  logic                           occ_w   [spjq_pkg::DEPTH];

  logic                           out_valid_r;
  spjq_pkg::status_t              out_status_r;
  logic [spjq_pkg::HANDLE_W-1:0]  out_handle_r;
  logic [spjq_pkg::PRIO_W-1:0]    out_priority_r;
  logic [spjq_pkg::OCC_W-1:0]     out_occupancy_r;
  logic                           out_valid_nxt;

  // Handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == spjq_pkg::CNT_W'(spjq_pkg::DEPTH));
  assign empty    = (cnt_r == '0);

  // Operation broadcast to the chain
  always_comb begin
    ctl.ins    = accept && (in_kind == spjq_pkg::KIND_INSERT) && !full;
    ctl.rem    = accept && (in_kind == spjq_pkg::KIND_REMOVE) && !empty;
    ctl.handle = in_job_handle;
    ctl.prio   = in_priority_req;
  end

  // Count and status
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + spjq_pkg::CNT_W'(1);
    end else if (ctl.rem) begin
      cnt_nxt = cnt_r - spjq_pkg::CNT_W'(1);
    end
    if (in_kind == spjq_pkg::KIND_INSERT) begin
      status_nxt = full ? spjq_pkg::ST_FULL : spjq_pkg::ST_INSERTED;
    end else begin
      status_nxt = empty ? spjq_pkg::ST_EMPTY : spjq_pkg::ST_REMOVED;
    end
  end

  // Cell chain; slot i holds a job when i is below the count
  for (genvar i = 0; i < spjq_pkg::DEPTH; i++) begin : g_cell
    assign occ_w[i] = (cnt_r > spjq_pkg::CNT_W'(i));
    if (i == 0) begin : g_head
      spjq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ_w[i]),
        .prev_ent   ('0),
        .prev_place (1'b0),
        .next_ent   (ent_w[i+1]),
        .ent_o      (ent_w[i]),
        .place_o    (place_w[i])
      );
    end else if (i == spjq_pkg::DEPTH - 1) begin : g_tail
      spjq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ_w[i]),
        .prev_ent   (ent_w[i-1]),
        .prev_place (place_w[i-1]),
        .next_ent   ('0),
        .ent_o      (ent_w[i]),
        .place_o    (place_w[i])
      );
    end else begin : g_mid
      spjq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (occ_w[i]),
        .prev_ent   (ent_w[i-1]),
        .prev_place (place_w[i-1]),
        .next_ent   (ent_w[i+1]),
        .ent_o      (ent_w[i]),
        .place_o    (place_w[i])
      );
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status_nxt;
      out_handle_r    <= ctl.rem ? ent_w[0].handle : '0;
      out_priority_r  <= ctl.rem ? ent_w[0].prio : '0;
      out_occupancy_r <= spjq_pkg::OCC_W'(cnt_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_handle    = out_handle_r;
  assign out_priority  = out_priority_r;
  assign out_occupancy = out_occupancy_r;

endmodule

// ===== hdl/spjq_checker.sv =====
// Port-level checker for the stable priority job queue, bound to the top level
`include "stable_priority_job_queue_macros.svh"

module spjq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     out_status,
  input logic [spjq_pkg::HANDLE_W-1:0]  out_handle,
  input logic [spjq_pkg::PRIO_W-1:0]    out_priority,
  input logic [spjq_pkg::OCC_W-1:0]     out_occupancy
);

  // A held result keeps its payload
  `SPJQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_handle) && $stable(out_priority) && $stable(out_occupancy))

  // Only a successful remove carries a job
  `SPJQ_ASSERT_NOW(a_zero_payload, out_valid && (out_status != spjq_pkg::ST_REMOVED), (out_handle == '0) && (out_priority == '0))

  // A dropped insert means the queue stays full
  `SPJQ_ASSERT_NOW(a_full_occ, out_valid && (out_status == spjq_pkg::ST_FULL), out_occupancy == spjq_pkg::OCC_W'(spjq_pkg::DEPTH))

  // A remove on empty leaves the queue empty
  `SPJQ_ASSERT_NOW(a_empty_occ, out_valid && (out_status == spjq_pkg::ST_EMPTY), out_occupancy == '0)

  // A successful insert never reports an empty queue
  `SPJQ_ASSERT_NOW(a_ins_occ, out_valid && (out_status == spjq_pkg::ST_INSERTED), out_occupancy != '0)

endmodule

bind stable_priority_job_queue spjq_checker u_spjq_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the stable priority job queue with its own sorted-queue predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam int RESET_CYCLES = 12;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_REPORTS  = 10;

  // One job request as offered on the input channel
  typedef struct {
    logic                          kind;
    logic [spjq_pkg::HANDLE_W-1:0] handle;
    logic [spjq_pkg::PRIO_W-1:0]   prio;
    int unsigned                   gap;
  } job_req_t;

  // One result as the block should report it
  typedef struct {
    spjq_pkg::status_t             status;
    logic [spjq_pkg::HANDLE_W-1:0] handle;
    logic [spjq_pkg::PRIO_W-1:0]   prio;
    logic [spjq_pkg::OCC_W-1:0]    occ;
  } job_result_t;

  // Shape of one stretch of random traffic
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;
  typedef enum int {PR_FULL, PR_TIES, PR_EXTREME} prio_mode_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic                          in_kind         = spjq_pkg::KIND_INSERT;
  logic [spjq_pkg::HANDLE_W-1:0] in_job_handle   = '0;
  logic [spjq_pkg::PRIO_W-1:0]   in_priority_req = '0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic [1:0]                    out_status;
  logic [spjq_pkg::HANDLE_W-1:0] out_handle;
  logic [spjq_pkg::PRIO_W-1:0]   out_priority;
  logic [spjq_pkg::OCC_W-1:0]    out_occupancy;

  job_req_t          job_pending[$];
  spjq_pkg::entry_t  stored_jobs[$];
  job_result_t       expected_results[$];

  int unsigned total_jobs  = 0;
  int unsigned n_sent      = 0;
  int unsigned n_got       = 0;
  int unsigned n_err       = 0;
  int unsigned idle_cycles = 0;
  int unsigned status_seen[4];

  // Driver and monitor bookkeeping
  int unsigned drv_wait  = 0;
  bit          drv_armed = 1'b0;
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  job_req_t    drv_item;
  job_result_t mon_want;

  stable_priority_job_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_job_handle   (in_job_handle),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_handle      (out_handle),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

  always #5 clk = ~clk;

  // Queue a job request for the driver
  function automatic void add_job(logic kind, logic [spjq_pkg::HANDLE_W-1:0] handle,
                                  logic [spjq_pkg::PRIO_W-1:0] prio, int unsigned gap);
    job_req_t r;
    r.kind   = kind;
    r.handle = handle;
    r.prio   = prio;
    r.gap    = gap;
    job_pending.insert(job_pending.size(), r);
  endfunction

  // Apply one accepted request to the sorted job list and record its result
  function automatic void predict_job_result(job_req_t r);
    job_result_t      res;
    spjq_pkg::entry_t e;
    int               pos;
    res.status = spjq_pkg::ST_INSERTED;
    res.handle = '0;
    res.prio   = '0;
    if (r.kind == spjq_pkg::KIND_INSERT) begin
      if (stored_jobs.size() >= spjq_pkg::DEPTH) begin
        res.status = spjq_pkg::ST_FULL;
      end else begin
        // new job goes behind every job of lower or equal priority
        pos = 0;
        while (pos < stored_jobs.size() && stored_jobs[pos].prio <= r.prio) pos++;
        e.handle = r.handle;
        e.prio   = r.prio;
        stored_jobs.insert(pos, e);
      end
    end else begin
      if (stored_jobs.size() == 0) begin
        res.status = spjq_pkg::ST_EMPTY;
      end else begin
        e = stored_jobs.pop_front();
        res.status = spjq_pkg::ST_REMOVED;
        res.handle = e.handle;
        res.prio   = e.prio;
      end
    end
    res.occ = spjq_pkg::OCC_W'(stored_jobs.size());
    expected_results.insert(expected_results.size(), res);
  endfunction

  // Log a failure; only the first few are printed
  function automatic void report_failure(string what);
    n_err++;
    if (n_err <= MAX_REPORTS)
      $display("[%0t] %s", $realtime, what);
  endfunction

  // Driver: holds a stalled item, otherwise waits out the gap and offers the next one
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_job_result(drv_item);
        n_sent++;
      end
      if (!drv_armed && job_pending.size() > 0) begin
        drv_wait  = job_pending[0].gap;
        drv_armed = 1'b1;
      end
      if (drv_armed && drv_wait == 0) begin
        drv_item        = job_pending.pop_front();
        drv_armed       = 1'b0;
        in_valid        <= 1'b1;
        in_kind         <= drv_item.kind;
        in_job_handle   <= drv_item.handle;
        in_priority_req <= drv_item.prio;
      end else begin
        if (drv_armed) drv_wait--;
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and drives out_stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_got++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("unexpected result: status %0d handle %h prio %h occ %0d",
                                   out_status, out_handle, out_priority, out_occupancy));
        end else begin
          mon_want = expected_results.pop_front();
          status_seen[mon_want.status]++;
          if (out_status !== mon_want.status || out_handle !== mon_want.handle ||
              out_priority !== mon_want.prio || out_occupancy !== mon_want.occ)
            report_failure($sformatf(
              "result %0d: expected %s/%h/%h/%0d, got %0d/%h/%h/%0d", n_got,
              mon_want.status.name(), mon_want.handle, mon_want.prio, mon_want.occ,
              out_status, out_handle, out_priority, out_occupancy));
        end
        // long back-pressure twice in the run so the block stalls its input
        if (n_got == 300 || n_got == 900) hold_left = HOLD_CYCLES;
        // some stretches of results are taken without any stall
        rx_wait = ((n_got / 150) % 3 == 0) ? 0 : $urandom_range(0, 19);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Count cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    phase_t                      phase;
    prio_mode_t                  pmode;
    int unsigned                 len;
    int unsigned                 pct;
    int unsigned                 n_directed;
    bit                          calm;
    logic                        kind;
    logic [spjq_pkg::PRIO_W-1:0] prio;
    int                          k;

    // Directed: remove on empty, fill with extremes and ties, insert on full,
    // then drain the head to see sort order and first-in first-out ties
    add_job(spjq_pkg::KIND_REMOVE, 16'h1234, 16'h4321, $urandom_range(0, 19));
    add_job(spjq_pkg::KIND_INSERT, 16'hFFFF, 16'hFFFF, $urandom_range(0, 19));
    add_job(spjq_pkg::KIND_INSERT, 16'h0000, 16'h0000, $urandom_range(0, 19));
    add_job(spjq_pkg::KIND_INSERT, 16'hAAAA, 16'h0007, 0);
    add_job(spjq_pkg::KIND_INSERT, 16'h5555, 16'h0007, 0);
    add_job(spjq_pkg::KIND_INSERT, 16'h0001, 16'h0007, 0);
    add_job(spjq_pkg::KIND_INSERT, 16'h0002, 16'hFFFF, $urandom_range(0, 19));
    add_job(spjq_pkg::KIND_INSERT, 16'h0003, 16'h0000, 0);
    for (k = 0; k < 9; k++)
      add_job(spjq_pkg::KIND_INSERT, 16'(16'h0100 + k), 16'(8 * k + 3),
              $urandom_range(0, 19));
    add_job(spjq_pkg::KIND_INSERT, 16'hDEAD, 16'h0000, 0);
    for (k = 0; k < 5; k++)
      add_job(spjq_pkg::KIND_REMOVE, 16'hFFFF, 16'hFFFF, $urandom_range(0, 3));
    add_job(spjq_pkg::KIND_INSERT, 16'h00FF, 16'h0000, 0);
    n_directed = job_pending.size();

    // Random: stretches that fill, drain or mix, with varied priority spread
    while (job_pending.size() < n_directed + RANDOM_ITEMS) begin
      phase = phase_t'($urandom_range(0, 2));
      pmode = prio_mode_t'($urandom_range(0, 2));
      len   = $urandom_range(10, 60);
      calm  = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        pct = $urandom_range(0, 99);
        case (phase)
          PH_FILL:  kind = (pct < 85) ? spjq_pkg::KIND_INSERT : spjq_pkg::KIND_REMOVE;
          PH_DRAIN: kind = (pct < 85) ? spjq_pkg::KIND_REMOVE : spjq_pkg::KIND_INSERT;
          default:  kind = (pct < 50) ? spjq_pkg::KIND_INSERT : spjq_pkg::KIND_REMOVE;
        endcase
        case (pmode)
          PR_TIES:    prio = 16'($urandom_range(0, 7));
          PR_EXTREME: prio = $urandom_range(0, 1) ? {spjq_pkg::PRIO_W{1'b1}} : '0;
          default:    prio = 16'($urandom_range(0, 65535));
        endcase
        add_job(kind, 16'($urandom_range(0, 65535)), prio,
                calm ? 0 : $urandom_range(0, 19));
      end
    end
    total_jobs = job_pending.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < total_jobs || expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d jobs: %0d inserted, %0d removed, %0d dropped on full, %0d empty removes",
             n_sent, status_seen[spjq_pkg::ST_INSERTED], status_seen[spjq_pkg::ST_REMOVED],
             status_seen[spjq_pkg::ST_FULL], status_seen[spjq_pkg::ST_EMPTY]);
    $display("Mismatches found: %0d", n_err);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/spjq_pkg.sv
hdl/spjq_cell.sv
hdl/stable_priority_job_queue.sv
hdl/spjq_checker.sv
tb/tb_top.sv
